// File: src/assert_macros.svh
// Concurrent assertion macros shared by the scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

// File: src/sts_pkg.sv
// Shared types, character codes and helpers of the S-expression token scanner.
package sts_pkg;

  localparam int unsigned POS_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [63:0] LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIMIT_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAG_GUARD = 64'd922337203685477580;

  typedef enum logic [2:0] {
    KIND_INT    = 3'd0,
    KIND_SYMBOL = 3'd1,
    KIND_BOOL   = 3'd2,
    KIND_LPAREN = 3'd3,
    KIND_RPAREN = 3'd4,
    KIND_END    = 3'd5,
    KIND_ERROR  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_HASH = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_TOO_LONG = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    SIGN_NONE  = 2'd0,
    SIGN_MINUS = 2'd1,
    SIGN_PLUS  = 2'd2
  } sign_e;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_WORD    = 5'b00010,
    MODE_COMMENT = 5'b00100,
    MODE_HASH    = 5'b01000,
    MODE_ERROR   = 5'b10000
  } mode_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] int_value;
    logic        bool_value;
    logic [15:0] text_start;
    logic [15:0] text_length;
    err_e        error_code;
  } res_t;

  typedef struct packed {
    res_t  first;
    logic  pair;
    kind_e second;
  } rec_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL) ||
           (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
  endfunction

  function automatic logic is_word_break(input logic [7:0] b);
    return is_space(b) || (b == CH_LPAREN) || (b == CH_RPAREN) ||
           (b == CH_LBRACK) || (b == CH_RBRACK) || (b == CH_SEMI);
  endfunction

endpackage

// File: src/sts_front.sv
// Front end: accepts bytes, tracks scan state, builds at most one result record per byte.
`include "assert_macros.svh"

module sts_front #(
  parameter int unsigned POS_BITS = sts_pkg::POS_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [7:0]          byte_req_i,
  output logic                push_o,
  output sts_pkg::rec_t       rec_o,
  input  logic                full_i
);

  sts_pkg::mode_e        mode_q, mode_d;
  logic [POS_BITS-1:0]   pos_q, pos_d;
  logic [POS_BITS-1:0]   ws_q, ws_d;
  logic [POS_BITS-1:0]   wl_q, wl_d;
  sts_pkg::sign_e        sign_q, sign_d;
  logic                  digits_q, digits_d;
  logic                  only_q, only_d;
  logic [63:0]           mag_q, mag_d;
  logic                  big_q, big_d;

  logic                  accept;
  logic [7:0]            b;
  logic                  b_lp, b_rp;
  logic                  in_word;

  logic [POS_BITS-1:0]   base_len;
  sts_pkg::sign_e        base_sign;
  logic                  base_digits, base_only, base_big;
  logic [63:0]           base_mag;

  logic                  a_sign, a_digit, a_num;
  logic [63:0]           mag_x10;
  sts_pkg::sign_e        add_sign;
  logic                  add_digits, add_only, add_big;
  logic [63:0]           add_mag;
  logic [POS_BITS-1:0]   add_len;

  logic                  w_int, w_neg, w_err;
  sts_pkg::res_t         word_res;
  logic [POS_BITS+15:0]  ws_ext, wl_ext;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign b          = byte_req_i;
  assign b_lp       = (b == sts_pkg::CH_LPAREN) || (b == sts_pkg::CH_LBRACK);
  assign b_rp       = (b == sts_pkg::CH_RPAREN) || (b == sts_pkg::CH_RBRACK);
  assign in_word    = (mode_q == sts_pkg::MODE_WORD);

  assign base_len    = in_word ? wl_q : '0;
  assign base_sign   = in_word ? sign_q : sts_pkg::SIGN_NONE;
  assign base_digits = in_word ? digits_q : 1'b0;
  assign base_only   = in_word ? only_q : 1'b1;
  assign base_mag    = in_word ? mag_q : '0;
  assign base_big    = in_word ? big_q : 1'b0;

  assign a_sign  = (base_len == '0) &&
                   ((b == sts_pkg::CH_MINUS) || (b == sts_pkg::CH_PLUS));
  assign a_digit = (b >= sts_pkg::CH_ZERO) && (b <= sts_pkg::CH_NINE);
  assign a_num   = !a_sign && a_digit;
  assign mag_x10 = (base_mag << 3) + (base_mag << 1) + {60'd0, b[3:0]};

  always_comb begin
    add_sign   = base_sign;
    add_digits = base_digits | a_num;
    add_only   = base_only & (a_sign | a_digit);
    add_mag    = base_mag;
    add_big    = base_big;
    add_len    = base_len + 1'b1;
    if (a_sign) begin
      add_sign = (b == sts_pkg::CH_MINUS) ? sts_pkg::SIGN_MINUS : sts_pkg::SIGN_PLUS;
    end
    if (a_num && !base_big) begin
      if (base_mag > sts_pkg::MAG_GUARD) begin
        add_big = 1'b1;
      end else if (mag_x10 > sts_pkg::LIMIT_NEG) begin
        add_big = 1'b1;
      end else begin
        add_mag = mag_x10;
      end
    end
  end

  assign ws_ext = {16'd0, ws_q};
  assign wl_ext = {16'd0, wl_q};
  assign w_int  = only_q && digits_q;
  assign w_neg  = (sign_q == sts_pkg::SIGN_MINUS);
  assign w_err  = w_int && (big_q || (w_neg ? (mag_q > sts_pkg::LIMIT_NEG)
                                            : (mag_q > sts_pkg::LIMIT_POS)));

  always_comb begin
    word_res = '0;
    if (!w_int) begin
      word_res.kind        = sts_pkg::KIND_SYMBOL;
      word_res.text_start  = ws_ext[15:0];
      word_res.text_length = wl_ext[15:0];
    end else if (w_err) begin
      word_res.kind       = sts_pkg::KIND_ERROR;
      word_res.error_code = sts_pkg::ERR_OVERFLOW;
    end else begin
      word_res.kind      = sts_pkg::KIND_INT;
      word_res.int_value = w_neg ? (64'd0 - mag_q) : mag_q;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    ws_d     = ws_q;
    wl_d     = wl_q;
    sign_d   = sign_q;
    digits_d = digits_q;
    only_d   = only_q;
    mag_d    = mag_q;
    big_d    = big_q;
    push_o   = 1'b0;
    rec_o    = '0;
    if (accept) begin
      if (op_i == sts_pkg::OP_END) begin
        push_o = 1'b1;
        case (mode_q)
          sts_pkg::MODE_WORD: begin
            rec_o.first  = word_res;
            rec_o.pair   = 1'b1;
            rec_o.second = sts_pkg::KIND_END;
          end
          sts_pkg::MODE_HASH: begin
            rec_o.first.kind       = sts_pkg::KIND_ERROR;
            rec_o.first.error_code = sts_pkg::ERR_BAD_HASH;
            rec_o.pair             = 1'b1;
            rec_o.second           = sts_pkg::KIND_END;
          end
          default: begin
            rec_o.first.kind = sts_pkg::KIND_END;
          end
        endcase
        mode_d   = sts_pkg::MODE_IDLE;
        pos_d    = '0;
        ws_d     = '0;
        wl_d     = '0;
        sign_d   = sts_pkg::SIGN_NONE;
        digits_d = 1'b0;
        only_d   = 1'b1;
        mag_d    = '0;
        big_d    = 1'b0;
      end else if (mode_q != sts_pkg::MODE_ERROR) begin
        if (&pos_q) begin
          push_o                 = 1'b1;
          rec_o.first.kind       = sts_pkg::KIND_ERROR;
          rec_o.first.error_code = sts_pkg::ERR_TOO_LONG;
          mode_d   = sts_pkg::MODE_ERROR;
          ws_d     = '0;
          wl_d     = '0;
          sign_d   = sts_pkg::SIGN_NONE;
          digits_d = 1'b0;
          only_d   = 1'b1;
          mag_d    = '0;
          big_d    = 1'b0;
        end else begin
          pos_d = pos_q + 1'b1;
          case (mode_q)
            sts_pkg::MODE_COMMENT: begin
              if (b == sts_pkg::CH_NL) begin
                mode_d = sts_pkg::MODE_IDLE;
              end
            end
            sts_pkg::MODE_HASH: begin
              push_o = 1'b1;
              if ((b == sts_pkg::CH_T) || (b == sts_pkg::CH_F)) begin
                rec_o.first.kind       = sts_pkg::KIND_BOOL;
                rec_o.first.bool_value = (b == sts_pkg::CH_T);
                mode_d                 = sts_pkg::MODE_IDLE;
              end else begin
                rec_o.first.kind       = sts_pkg::KIND_ERROR;
                rec_o.first.error_code = sts_pkg::ERR_BAD_HASH;
                mode_d                 = sts_pkg::MODE_ERROR;
              end
            end
            sts_pkg::MODE_WORD: begin
              if (sts_pkg::is_word_break(b)) begin
                push_o      = 1'b1;
                rec_o.first = word_res;
                ws_d     = '0;
                wl_d     = '0;
                sign_d   = sts_pkg::SIGN_NONE;
                digits_d = 1'b0;
                only_d   = 1'b1;
                mag_d    = '0;
                big_d    = 1'b0;
                if (w_err) begin
                  mode_d = sts_pkg::MODE_ERROR;
                end else if (b == sts_pkg::CH_SEMI) begin
                  mode_d = sts_pkg::MODE_COMMENT;
                end else begin
                  mode_d = sts_pkg::MODE_IDLE;
                  if (b_lp) begin
                    rec_o.pair   = 1'b1;
                    rec_o.second = sts_pkg::KIND_LPAREN;
                  end else if (b_rp) begin
                    rec_o.pair   = 1'b1;
                    rec_o.second = sts_pkg::KIND_RPAREN;
                  end
                end
              end else begin
                wl_d     = add_len;
                sign_d   = add_sign;
                digits_d = add_digits;
                only_d   = add_only;
                mag_d    = add_mag;
                big_d    = add_big;
              end
            end
            sts_pkg::MODE_IDLE: begin
              if (sts_pkg::is_space(b)) begin
                mode_d = sts_pkg::MODE_IDLE;
              end else if (b == sts_pkg::CH_SEMI) begin
                mode_d = sts_pkg::MODE_COMMENT;
              end else if (b_lp) begin
                push_o           = 1'b1;
                rec_o.first.kind = sts_pkg::KIND_LPAREN;
              end else if (b_rp) begin
                push_o           = 1'b1;
                rec_o.first.kind = sts_pkg::KIND_RPAREN;
              end else if (b == sts_pkg::CH_HASH) begin
                mode_d = sts_pkg::MODE_HASH;
              end else begin
                mode_d   = sts_pkg::MODE_WORD;
                ws_d     = pos_q;
                wl_d     = add_len;
                sign_d   = add_sign;
                digits_d = add_digits;
                only_d   = add_only;
                mag_d    = add_mag;
                big_d    = add_big;
              end
            end
            default: begin
              mode_d = mode_q;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= sts_pkg::MODE_IDLE;
      pos_q    <= '0;
      ws_q     <= '0;
      wl_q     <= '0;
      sign_q   <= sts_pkg::SIGN_NONE;
      digits_q <= 1'b0;
      only_q   <= 1'b1;
      mag_q    <= '0;
      big_q    <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      ws_q     <= ws_d;
      wl_q     <= wl_d;
      sign_q   <= sign_d;
      digits_q <= digits_d;
      only_q   <= only_d;
      mag_q    <= mag_d;
      big_q    <= big_d;
    end
  end

  `ASSERT_CLK(a_front_word_len, clk_i, rst_ni, (mode_q != sts_pkg::MODE_WORD) |-> (wl_q == '0))
  `ASSERT_CLK(a_front_err_drop, clk_i, rst_ni, ((mode_q == sts_pkg::MODE_ERROR) && (op_i == sts_pkg::OP_BYTE)) |-> !push_o)

endmodule

// File: src/sts_queue.sv
// Short record queue between the front end and the result serializer.
`include "assert_macros.svh"

module sts_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sts_pkg::rec_t rec_i,
  output logic          full_o,
  input  logic          pop_i,
  output sts_pkg::rec_t head_o,
  output logic          empty_o
);

  localparam int unsigned QD  = sts_pkg::QUEUE_DEPTH;
  localparam int unsigned QAW = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned QCW = $clog2(QD + 1);

  sts_pkg::rec_t   mem_q [QD];
  logic [QAW-1:0]  wr_q, wr_d;
  logic [QAW-1:0]  rd_q, rd_d;
  logic [QCW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCW'(QD));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QAW'(QD - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QAW'(QD - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `ASSERT_NEVER(a_queue_no_overflow, clk_i, rst_ni, push_i && full_o)
  `ASSERT_NEVER(a_queue_no_underflow, clk_i, rst_ni, pop_i && empty_o)

endmodule

// File: src/sts_back.sv
// Back end: serializes queued records into output beats through an output register.
`include "assert_macros.svh"

module sts_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sts_pkg::rec_t      head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic signed [63:0] int_value_o,
  output logic               bool_value_o,
  output logic [15:0]        text_start_o,
  output logic [15:0]        text_length_o,
  output logic [1:0]         error_code_o,
  output logic               last_of_run_o
);

  sts_pkg::res_t out_q, out_d;
  logic          last_q, last_d;
  logic          valid_q, valid_d;
  logic          pair_q, pair_d;
  logic          load;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    out_d   = out_q;
    last_d  = last_q;
    valid_d = valid_q;
    pair_d  = pair_q;
    pop_o   = 1'b0;
    if (load) begin
      if (pair_q) begin
        out_d      = '0;
        out_d.kind = head_i.second;
        last_d     = 1'b1;
        valid_d    = 1'b1;
        pair_d     = 1'b0;
        pop_o      = 1'b1;
      end else if (!empty_i) begin
        out_d   = head_i.first;
        last_d  = !head_i.pair;
        valid_d = 1'b1;
        pair_d  = head_i.pair;
        pop_o   = !head_i.pair;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pair_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pair_q  <= pair_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = out_q.kind;
  assign int_value_o   = $signed(out_q.int_value);
  assign bool_value_o  = out_q.bool_value;
  assign text_start_o  = out_q.text_start;
  assign text_length_o = out_q.text_length;
  assign error_code_o  = out_q.error_code;
  assign last_of_run_o = last_q;

  `ASSERT_CLK(a_back_pair_holds_first, clk_i, rst_ni, pair_q |-> (valid_q && !last_q))
  `ASSERT_CLK(a_back_second_last, clk_i, rst_ni, (load && pair_q) |=> (valid_q && last_q))

endmodule

// File: src/sexpr_token_scanner.sv
// An accepted byte's results pass through the record queue and then the output register.
// Throughput: one byte per cycle unless the queue is full; two results leave as two beats.
// The single output register gives one result beat per cycle while out_stall_i is low.
// A four-record queue lets the byte side run ahead while the result side stalls.
// Reset (rst_ni low, asynchronous) returns to idle scan, position zero, queue empty.
// Top level of the S-expression token scanner.
module sexpr_token_scanner #(
  parameter int unsigned POS_BITS = sts_pkg::POS_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [7:0]         byte_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic signed [63:0] int_value_o,
  output logic               bool_value_o,
  output logic [15:0]        text_start_o,
  output logic [15:0]        text_length_o,
  output logic [1:0]         error_code_o,
  output logic               last_of_run_o
);

  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  sts_pkg::rec_t rec;
  sts_pkg::rec_t head;

  sts_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .byte_req_i (byte_req_i),
    .push_o     (push),
    .rec_o      (rec),
    .full_i     (full)
  );

  sts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  sts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .int_value_o   (int_value_o),
    .bool_value_o  (bool_value_o),
    .text_start_o  (text_start_o),
    .text_length_o (text_length_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: bench/tb_sexpr_token_scanner.sv
// Self-checking testbench of the S-expression token scanner.
`timescale 1ns / 100ps

module tb_sexpr_token_scanner;

  localparam logic [31:0] POS_LIMIT = (32'd1 << sts_pkg::POS_BITS_DEF) - 32'd1;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASE_BYTES = 130;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } beat_t;

  typedef struct packed {
    sts_pkg::res_t tok;
    logic          last;
  } tok_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic op_i = sts_pkg::OP_BYTE;
  logic [7:0] byte_req_i = 8'h00;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] kind_o;
  logic signed [63:0] int_value_o;
  logic bool_value_o;
  logic [15:0] text_start_o;
  logic [15:0] text_length_o;
  logic [1:0] error_code_o;
  logic last_of_run_o;

  beat_t src_q[$];
  tok_exp_t step_q[$];
  tok_exp_t token_q[$];
  int fed = 0;
  int mismatches = 0;
  int unsigned send_idle_pct = 17;
  int unsigned recv_stall_pct = 66;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned idle_cycles = 0;

  // scanner state as predicted
  sts_pkg::mode_e scan_mode = sts_pkg::MODE_IDLE;
  logic [31:0] scan_pos = '0;
  logic [31:0] word_start = '0;
  logic [31:0] word_len = '0;
  sts_pkg::sign_e word_sign = sts_pkg::SIGN_NONE;
  bit saw_digit = 1'b0;
  bit all_digits = 1'b1;
  bit too_big = 1'b0;
  logic [63:0] magnitude = '0;

  sexpr_token_scanner DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .byte_req_i   (byte_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .int_value_o  (int_value_o),
    .bool_value_o (bool_value_o),
    .text_start_o (text_start_o),
    .text_length_o(text_length_o),
    .error_code_o (error_code_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit blank_char(input logic [7:0] c);
    case (c)
      sts_pkg::CH_SPACE, sts_pkg::CH_TAB, sts_pkg::CH_NL, sts_pkg::CH_VT,
      sts_pkg::CH_FF, sts_pkg::CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit ends_word(input logic [7:0] c);
    case (c)
      sts_pkg::CH_LPAREN, sts_pkg::CH_RPAREN, sts_pkg::CH_LBRACK, sts_pkg::CH_RBRACK,
      sts_pkg::CH_SEMI: return 1'b1;
      default: return blank_char(c);
    endcase
  endfunction

  function automatic void clear_word();
    word_start = '0;
    word_len = '0;
    word_sign = sts_pkg::SIGN_NONE;
    saw_digit = 1'b0;
    all_digits = 1'b1;
    magnitude = '0;
    too_big = 1'b0;
  endfunction

  function automatic void reset_scan();
    scan_mode = sts_pkg::MODE_IDLE;
    scan_pos = '0;
    clear_word();
  endfunction

  function automatic void note_token(input sts_pkg::kind_e k, input logic [63:0] iv,
                                     input logic bv, input logic [31:0] ts,
                                     input logic [31:0] tl, input sts_pkg::err_e ec);
    tok_exp_t t;
    t.tok.kind = k;
    t.tok.int_value = iv;
    t.tok.bool_value = bv;
    t.tok.text_start = ts[15:0];
    t.tok.text_length = tl[15:0];
    t.tok.error_code = ec;
    t.last = 1'b0;
    step_q = {step_q, t};
  endfunction

  function automatic void grow_word(input logic [7:0] c);
    logic [63:0] nm;
    if (word_len == 0 && (c == sts_pkg::CH_MINUS || c == sts_pkg::CH_PLUS)) begin
      word_sign = (c == sts_pkg::CH_MINUS) ? sts_pkg::SIGN_MINUS : sts_pkg::SIGN_PLUS;
    end else if (c >= sts_pkg::CH_ZERO && c <= sts_pkg::CH_NINE) begin
      saw_digit = 1'b1;
      if (!too_big) begin
        if (magnitude > sts_pkg::MAG_GUARD) begin
          too_big = 1'b1;
        end else begin
          nm = magnitude * 64'd10 + 64'(c - sts_pkg::CH_ZERO);
          if (nm > sts_pkg::LIMIT_NEG) too_big = 1'b1;
          else magnitude = nm;
        end
      end
    end else begin
      all_digits = 1'b0;
    end
    word_len = word_len + 32'd1;
  endfunction

  // emit the pending word; true when it overflowed
  function automatic bit close_word();
    bit bad;
    bad = 1'b0;
    if (all_digits && saw_digit) begin
      if (word_sign == sts_pkg::SIGN_MINUS) begin
        if (too_big || magnitude > sts_pkg::LIMIT_NEG) bad = 1'b1;
        else note_token(sts_pkg::KIND_INT, ~magnitude + 64'd1, 1'b0, '0, '0,
                        sts_pkg::ERR_NONE);
      end else if (too_big || magnitude > sts_pkg::LIMIT_POS) begin
        bad = 1'b1;
      end else begin
        note_token(sts_pkg::KIND_INT, magnitude, 1'b0, '0, '0, sts_pkg::ERR_NONE);
      end
      if (bad) note_token(sts_pkg::KIND_ERROR, '0, 1'b0, '0, '0, sts_pkg::ERR_OVERFLOW);
    end else begin
      note_token(sts_pkg::KIND_SYMBOL, '0, 1'b0, word_start, word_len, sts_pkg::ERR_NONE);
    end
    clear_word();
    return bad;
  endfunction

  function automatic void scan_beat(input logic op, input logic [7:0] c);
    logic [31:0] at;
    step_q.delete();
    if (op == sts_pkg::OP_END) begin
      if (scan_mode == sts_pkg::MODE_WORD) void'(close_word());
      else if (scan_mode == sts_pkg::MODE_HASH)
        note_token(sts_pkg::KIND_ERROR, '0, 1'b0, '0, '0, sts_pkg::ERR_BAD_HASH);
      note_token(sts_pkg::KIND_END, '0, 1'b0, '0, '0, sts_pkg::ERR_NONE);
      reset_scan();
    end else if (scan_mode != sts_pkg::MODE_ERROR) begin
      if (scan_pos >= POS_LIMIT) begin
        note_token(sts_pkg::KIND_ERROR, '0, 1'b0, '0, '0, sts_pkg::ERR_TOO_LONG);
        clear_word();
        scan_mode = sts_pkg::MODE_ERROR;
      end else begin
        at = scan_pos;
        scan_pos = (scan_pos + 32'd1) & POS_LIMIT;
        case (scan_mode)
          sts_pkg::MODE_COMMENT: if (c == sts_pkg::CH_NL) scan_mode = sts_pkg::MODE_IDLE;
          sts_pkg::MODE_HASH: begin
            if (c == sts_pkg::CH_T || c == sts_pkg::CH_F) begin
              note_token(sts_pkg::KIND_BOOL, '0, c == sts_pkg::CH_T, '0, '0,
                         sts_pkg::ERR_NONE);
              scan_mode = sts_pkg::MODE_IDLE;
            end else begin
              note_token(sts_pkg::KIND_ERROR, '0, 1'b0, '0, '0, sts_pkg::ERR_BAD_HASH);
              scan_mode = sts_pkg::MODE_ERROR;
            end
          end
          default: begin
            if (scan_mode == sts_pkg::MODE_WORD) begin
              if (ends_word(c))
                scan_mode = close_word() ? sts_pkg::MODE_ERROR : sts_pkg::MODE_IDLE;
              else grow_word(c);
            end
            if (scan_mode == sts_pkg::MODE_IDLE) begin
              if (c == sts_pkg::CH_SEMI) begin
                scan_mode = sts_pkg::MODE_COMMENT;
              end else if (c == sts_pkg::CH_LPAREN || c == sts_pkg::CH_LBRACK) begin
                note_token(sts_pkg::KIND_LPAREN, '0, 1'b0, '0, '0, sts_pkg::ERR_NONE);
              end else if (c == sts_pkg::CH_RPAREN || c == sts_pkg::CH_RBRACK) begin
                note_token(sts_pkg::KIND_RPAREN, '0, 1'b0, '0, '0, sts_pkg::ERR_NONE);
              end else if (c == sts_pkg::CH_HASH) begin
                scan_mode = sts_pkg::MODE_HASH;
              end else if (!blank_char(c)) begin
                clear_word();
                word_start = at;
                grow_word(c);
                scan_mode = sts_pkg::MODE_WORD;
              end
            end
          end
        endcase
      end
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) token_q = {token_q, step_q[i]};
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  task automatic check_token();
    tok_exp_t want;
    if (token_q.size() == 0) begin
      mismatches++;
      $display("%0t: kind expected none, got %0d", $time, kind_o);
    end else begin
      want = token_q.pop_front();
      compare_field("kind", want.tok.kind, kind_o);
      compare_field("int_value", want.tok.int_value, int_value_o);
      compare_field("bool_value", want.tok.bool_value, bool_value_o);
      compare_field("text_start", want.tok.text_start, text_start_o);
      compare_field("text_length", want.tok.text_length, text_length_o);
      compare_field("error_code", want.tok.error_code, error_code_o);
      compare_field("last_of_run", want.last, last_of_run_o);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : feed
    beat_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i <= sts_pkg::OP_BYTE;
      byte_req_i <= 8'h00;
    end else begin
      if (in_valid_i && !in_stall_o) scan_beat(op_i, byte_req_i);
      if (!in_valid_i || !in_stall_o) begin
        if (src_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = src_q.pop_front();
          in_valid_i <= 1'b1;
          op_i <= nxt.op;
          byte_req_i <= nxt.ch;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_token();
      if (hold_go && !hold_done) begin
        hold_cnt <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_stall_i <= 1'b1;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic put_byte(input logic [7:0] c);
    beat_t b;
    b.op = sts_pkg::OP_BYTE;
    b.ch = c;
    src_q = {src_q, b};
    fed++;
  endtask

  task automatic put_end();
    beat_t b;
    b.op = sts_pkg::OP_END;
    b.ch = 8'($urandom_range(255));
    src_q = {src_q, b};
    fed++;
  endtask

  task automatic put_text(input string s);
    foreach (s[i]) put_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(5))
      0: return sts_pkg::CH_SPACE;
      1: return sts_pkg::CH_TAB;
      2: return sts_pkg::CH_NL;
      3: return sts_pkg::CH_VT;
      4: return sts_pkg::CH_FF;
      default: return sts_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_delim();
    case ($urandom_range(7))
      0: return sts_pkg::CH_LPAREN;
      1: return sts_pkg::CH_RPAREN;
      2: return sts_pkg::CH_LBRACK;
      3: return sts_pkg::CH_RBRACK;
      default: return pick_blank();
    endcase
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (ends_word(c));
    return c;
  endfunction

  task automatic put_sign();
    case ($urandom_range(2))
      0: put_byte(sts_pkg::CH_MINUS);
      1: put_byte(sts_pkg::CH_PLUS);
      default: ;
    endcase
  endtask

  task automatic put_digits(input int unsigned n);
    repeat (n) put_byte(sts_pkg::CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic put_token();
    int unsigned pick;
    int unsigned n;
    logic [7:0] c;
    pick = $urandom_range(15);
    case (pick)
      0, 1: put_byte(pick_blank());
      2: put_byte($urandom_range(1) ? sts_pkg::CH_LPAREN : sts_pkg::CH_LBRACK);
      3: put_byte($urandom_range(1) ? sts_pkg::CH_RPAREN : sts_pkg::CH_RBRACK);
      4, 5: begin
        put_sign();
        put_digits($urandom_range(1, 6));
      end
      6: case ($urandom_range(5))
        0: put_text("9223372036854775807");
        1: put_text("-9223372036854775808");
        2: put_text("+9223372036854775808");
        3: put_text("-9223372036854775809");
        4: put_text("18446744073709551616");
        default: begin
          put_sign();
          put_digits($urandom_range(17, 24));
        end
      endcase
      7, 8: begin
        do c = word_char(); while (c == sts_pkg::CH_HASH);
        put_byte(c);
        n = $urandom_range(0, 5);
        repeat (n) put_byte(word_char());
      end
      9: put_byte($urandom_range(1) ? sts_pkg::CH_MINUS : sts_pkg::CH_PLUS);
      10: begin
        put_byte(sts_pkg::CH_HASH);
        put_byte($urandom_range(1) ? sts_pkg::CH_T : sts_pkg::CH_F);
      end
      11: begin
        put_byte(sts_pkg::CH_HASH);
        put_byte($urandom_range(1) ? sts_pkg::CH_T : sts_pkg::CH_F);
        put_byte(word_char());
      end
      12: begin
        put_byte(sts_pkg::CH_SEMI);
        n = $urandom_range(0, 6);
        repeat (n) begin
          do c = 8'($urandom_range(255)); while (c == sts_pkg::CH_NL);
          put_byte(c);
        end
        put_byte(sts_pkg::CH_NL);
      end
      13: begin
        put_sign();
        put_digits($urandom_range(1, 3));
        put_byte(word_char());
      end
      14: begin
        if ($urandom_range(3) == 0) begin
          put_byte(sts_pkg::CH_HASH);
          do c = 8'($urandom_range(255)); while (c == sts_pkg::CH_T || c == sts_pkg::CH_F);
          put_byte(c);
        end else begin
          put_byte(pick_blank());
        end
      end
      default: put_byte(8'($urandom_range(255)));
    endcase
    if ($urandom_range(3) != 0) put_byte(pick_delim());
  endtask

  task automatic put_source(input int unsigned n);
    repeat (n) put_token();
    if ($urandom_range(7) == 0) put_byte(sts_pkg::CH_HASH);
    put_end();
  endtask

  task automatic put_phase();
    int start;
    start = fed;
    while (fed - start < PHASE_BYTES) put_source($urandom_range(3, 12));
  endtask

  task automatic wait_drained();
    while (src_q.size() != 0 || in_valid_i || token_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    reset_scan();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    put_text("(a1 -7)#t#f;c\n[+ ]#tx #");
    put_end();
    put_text("#q");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_end();
    wait_drained();

    put_phase();
    wait_drained();

    send_idle_pct <= 66;
    recv_stall_pct <= 17;
    @(negedge clk_i);
    put_phase();
    wait_drained();

    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    hold_go <= 1'b1;
    @(negedge clk_i);
    put_text("(((((((((())))))))))");
    put_phase();
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
